// ===== hw/rtl/nhm_pkg.sv =====
// shared types and constants of the heat map colorizer
// no dependencies; used by every other rtl file
`default_nettype none

package nhm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int LEVEL_W   = 8;
  localparam int NUM_STOPS = 5;
  localparam int LEVEL_MAX = 255;

  // register indexes
  typedef enum logic {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } reg_idx_t;

  // how a sample is colored once it is normalized
  typedef enum logic [1:0] {
    PIX_BLUE,
    PIX_RED,
    PIX_RAMP
  } pix_class_t;

  typedef struct packed {
    logic       valid;
    pix_class_t cls;
  } pix_ctl_t;

  // color stops, bits {red, green, blue}: blue, cyan, green, yellow, red
  localparam logic [2:0] STOP_RGB [NUM_STOPS] = '{
    3'b001, 3'b011, 3'b010, 3'b110, 3'b100
  };

endpackage

`default_nettype wire

// ===== hw/rtl/nhm_sample_if.sv =====
// input channel of the colorizer: one signed q16.16 sample per beat
// depends on nhm_pkg
`default_nettype none

interface nhm_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [nhm_pkg::DATA_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nhm_color_if.sv =====
// output channel of the colorizer: one 8-bit rgb color per beat
// depends on nhm_pkg
`default_nettype none

interface nhm_color_if;
  logic                        valid;
  logic                        ready;
  logic [nhm_pkg::LEVEL_W-1:0] red_level;
  logic [nhm_pkg::LEVEL_W-1:0] green_level;
  logic [nhm_pkg::LEVEL_W-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nhm_front.sv =====
// front stages: offset and span against the range, sign fold and clamp decision
// depends on nhm_pkg
`default_nettype none

module nhm_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire logic                              in_valid,
  input  wire logic signed [nhm_pkg::DATA_W-1:0] sample_value,
  input  wire logic signed [nhm_pkg::DATA_W-1:0] range_low,
  input  wire logic signed [nhm_pkg::DATA_W-1:0] range_high,
  output nhm_pkg::pix_ctl_t                      out_ctl,
  output logic             [nhm_pkg::DATA_W-1:0] out_num,
  output logic             [nhm_pkg::DATA_W-1:0] out_den
);

  localparam int W = nhm_pkg::DATA_W;

  // stage 1: exact differences
  logic              valid1;
  logic signed [W:0] num1;
  logic signed [W:0] den1;

  // stage 2 combinational
  logic              den_zero;
  logic              den_neg;
  logic signed [W:0] num_abs;
  logic signed [W:0] den_abs;
  nhm_pkg::pix_class_t cls_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1 <= (W+1)'(sample_value) - (W+1)'(range_low);
      den1 <= (W+1)'(range_high) - (W+1)'(range_low);
    end
  end

  // a reversed range negates both; the clamp tests are flipped instead of
  // waiting for the negation
  always_comb begin
    den_zero = (den1 == '0);
    den_neg  = den1[W];
    num_abs  = den_neg ? -num1 : num1;
    den_abs  = den_neg ? -den1 : den1;
    priority if (den_zero) begin
      cls_next = (num1 > 0) ? nhm_pkg::PIX_RED : nhm_pkg::PIX_BLUE;
    end else if (!den_neg) begin
      priority if (num1 <= 0)         cls_next = nhm_pkg::PIX_BLUE;
      else if (num1 >= den1)          cls_next = nhm_pkg::PIX_RED;
      else                            cls_next = nhm_pkg::PIX_RAMP;
    end else begin
      priority if (num1 >= 0)         cls_next = nhm_pkg::PIX_BLUE;
      else if (num1 <= den1)          cls_next = nhm_pkg::PIX_RED;
      else                            cls_next = nhm_pkg::PIX_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (adv) begin
      out_ctl.valid <= valid1;
    end
    if (adv) begin
      out_ctl.cls <= cls_next;
      out_num     <= num_abs[W-1:0];
      out_den     <= den_abs[W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nhm_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on nhm_pkg; expects num < den for ramp samples
`default_nettype none

module nhm_divider #(
  parameter int FRAC_BITS = nhm_pkg::FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             adv,
  input  nhm_pkg::pix_ctl_t                     in_ctl,
  input  wire logic [nhm_pkg::DATA_W-1:0]       in_num,
  input  wire logic [nhm_pkg::DATA_W-1:0]       in_den,
  output nhm_pkg::pix_ctl_t                     out_ctl,
  output logic      [FRAC_BITS-1:0]             out_quo
);

  localparam int W = nhm_pkg::DATA_W;

  logic [W-1:0]         rem      [FRAC_BITS];
  logic [W-1:0]         den      [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo      [FRAC_BITS];
  nhm_pkg::pix_ctl_t    ctl      [FRAC_BITS];

  logic [W-1:0]         rem_next [FRAC_BITS];
  logic [W-1:0]         den_next [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_next [FRAC_BITS];
  nhm_pkg::pix_ctl_t    ctl_next [FRAC_BITS];

  always_comb begin
    logic [W:0]           shifted;
    logic [W:0]           diff;
    logic [W-1:0]         rem_src;
    logic [FRAC_BITS-1:0] quo_src;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (i == 0) begin
        rem_src     = in_num;
        quo_src     = '0;
        den_next[i] = in_den;
        ctl_next[i] = in_ctl;
      end else begin
        rem_src     = rem[i-1];
        quo_src     = quo[i-1];
        den_next[i] = den[i-1];
        ctl_next[i] = ctl[i-1];
      end
      shifted = {rem_src, 1'b0};
      diff    = shifted - {1'b0, den_next[i]};
      // no borrow means the doubled remainder reached the divisor
      if (!diff[W]) begin
        rem_next[i] = diff[W-1:0];
        quo_next[i] = {quo_src[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[W-1:0];
        quo_next[i] = {quo_src[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (rst) begin
        ctl[i].valid <= 1'b0;
      end else if (adv) begin
        ctl[i].valid <= ctl_next[i].valid;
      end
      if (adv) begin
        ctl[i].cls <= ctl_next[i].cls;
        rem[i]     <= rem_next[i];
        den[i]     <= den_next[i];
        quo[i]     <= quo_next[i];
      end
    end
  end

  assign out_ctl = ctl[FRAC_BITS-1];
  assign out_quo = quo[FRAC_BITS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/nhm_ramp.sv =====
// color ramp stages: stop select and blend weight, then scale to 8-bit levels
// depends on nhm_pkg; the last register here is the output register
`default_nettype none

module nhm_ramp #(
  parameter int FRAC_BITS = nhm_pkg::FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  nhm_pkg::pix_ctl_t                in_ctl,
  input  wire logic [FRAC_BITS-1:0]        in_quo,
  output logic                             out_valid,
  output logic      [nhm_pkg::LEVEL_W-1:0] red_level,
  output logic      [nhm_pkg::LEVEL_W-1:0] green_level,
  output logic      [nhm_pkg::LEVEL_W-1:0] blue_level
);

  localparam int CW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 9;
  localparam int LW = nhm_pkg::LEVEL_W;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  // stage 1: interpolated components in q1.frac
  logic [1:0]           idx;
  logic [2:0]           idx_hi;
  logic [FRAC_BITS-1:0] frac;
  logic [2:0]           rgb_lo;
  logic [2:0]           rgb_hi;
  logic [CW-1:0]        comp_next [3];

  nhm_pkg::pix_ctl_t    ctl1;
  logic [CW-1:0]        comp      [3];

  // stage 2
  logic [PW-1:0]        prod      [3];
  logic [LW-1:0]        level     [3];
  logic [2:0]           edge_rgb;

  // four times the fraction: top two bits pick the segment
  always_comb begin
    idx    = in_quo[FRAC_BITS-1 -: 2];
    idx_hi = {1'b0, idx} + 3'd1;
    frac   = {in_quo[FRAC_BITS-3:0], 2'b00};
    rgb_lo = nhm_pkg::STOP_RGB[{1'b0, idx}];
    rgb_hi = nhm_pkg::STOP_RGB[idx_hi];
    for (int k = 0; k < 3; k++) begin
      if (rgb_lo[2-k] == rgb_hi[2-k]) begin
        comp_next[k] = rgb_lo[2-k] ? ONE : '0;
      end else if (rgb_hi[2-k]) begin
        comp_next[k] = {1'b0, frac};
      end else begin
        comp_next[k] = ONE - {1'b0, frac};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (adv) begin
      ctl1.valid <= in_ctl.valid;
    end
    if (adv) begin
      ctl1.cls <= in_ctl.cls;
      for (int k = 0; k < 3; k++) begin
        comp[k] <= comp_next[k];
      end
    end
  end

  always_comb begin
    unique case (ctl1.cls)
      nhm_pkg::PIX_BLUE: edge_rgb = nhm_pkg::STOP_RGB[0];
      nhm_pkg::PIX_RED:  edge_rgb = nhm_pkg::STOP_RGB[nhm_pkg::NUM_STOPS-1];
      default:           edge_rgb = '0;
    endcase
    for (int k = 0; k < 3; k++) begin
      prod[k] = PW'(comp[k]) * PW'(nhm_pkg::LEVEL_MAX);
      if (ctl1.cls == nhm_pkg::PIX_RAMP) begin
        level[k] = prod[k][FRAC_BITS +: LW];
      end else begin
        level[k] = edge_rgb[2-k] ? LW'(nhm_pkg::LEVEL_MAX) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_level   <= level[0];
      green_level <= level[1];
      blue_level  <= level[2];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/normalized_heat_map_colorizer_unit.sv =====
// Heat map colorizer: maps each signed Q16.16 sample onto a blue-cyan-green-yellow-red
// ramp normalized to the range held in range_low / range_high (APB registers at 0x0
// and 0x4). One sample is accepted every clock unless the output stalls. The depth
// is set by the pipelined divider, which forms the fraction one quotient bit per
// stage, plus two front and two ramp stages. A stall on the output holds the whole
// pipe; the user must change ranges only while it is empty; nothing here enforces it.
// depends on nhm_pkg, nhm_sample_if, nhm_color_if, nhm_front, nhm_divider, nhm_ramp
`default_nettype none

module normalized_heat_map_colorizer_unit #(
  parameter int FRAC_BITS = nhm_pkg::FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  nhm_sample_if.sink                        sample,
  nhm_color_if.source                       color,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [nhm_pkg::DATA_W-1:0]   pwdata,
  output logic      [nhm_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int W = nhm_pkg::DATA_W;

  logic signed [W-1:0] range_low;
  logic signed [W-1:0] range_high;
  nhm_pkg::reg_idx_t   reg_sel;

  logic                adv;
  nhm_pkg::pix_ctl_t   front_ctl;
  logic [W-1:0]        front_num;
  logic [W-1:0]        front_den;
  nhm_pkg::pix_ctl_t   div_ctl;
  logic [FRAC_BITS-1:0] div_quo;

  assign pready  = 1'b1;
  assign reg_sel = nhm_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= W'(65536);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        nhm_pkg::REG_RANGE_LOW:  range_low  <= pwdata;
        nhm_pkg::REG_RANGE_HIGH: range_high <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      nhm_pkg::REG_RANGE_LOW:  prdata = range_low;
      nhm_pkg::REG_RANGE_HIGH: prdata = range_high;
    endcase
  end

  // the whole pipe moves unless a finished beat is stuck at the output
  assign adv          = !color.valid || color.ready;
  assign sample.ready = adv;

  nhm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (sample.valid),
    .sample_value (sample.sample_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .out_ctl      (front_ctl),
    .out_num      (front_num),
    .out_den      (front_den)
  );

  nhm_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (front_ctl),
    .in_num  (front_num),
    .in_den  (front_den),
    .out_ctl (div_ctl),
    .out_quo (div_quo)
  );

  nhm_ramp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_ctl      (div_ctl),
    .in_quo      (div_quo),
    .out_valid   (color.valid),
    .red_level   (color.red_level),
    .green_level (color.green_level),
    .blue_level  (color.blue_level)
  );

endmodule

`default_nettype wire
